// ===== hw/rtl/bfd_pkg.sv =====
// ----------------------------------------------------------------------------
// bfd_pkg: shared types, constants and the lane averaging function
// Sizes, format codes, the configuration bundle and the job passed from the
// front end to the back end of the 2x downsampler.
// ----------------------------------------------------------------------------
package bfd_pkg;

  localparam int MAX_WIDTH   = 4096;
  localparam int ROW_LIMIT   = 4096;
  localparam int PIX_W       = 32;
  localparam int CFG_DIM_W   = 13;
  localparam int CFG_FMT_W   = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int COL_W       = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W       = $clog2(ROW_LIMIT);
  localparam int DIM_W       = (COL_W + 1 > CFG_DIM_W) ? COL_W + 1 : CFG_DIM_W;
  localparam int BANK_DEPTH  = (MAX_WIDTH + 1) / 2;
  localparam int BANK_ADDR_W = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

  // pixel format codes
  localparam logic [CFG_FMT_W-1:0] FMT_R8    = 3'd0;
  localparam logic [CFG_FMT_W-1:0] FMT_RG8   = 3'd1;
  localparam logic [CFG_FMT_W-1:0] FMT_R16   = 3'd2;
  localparam logic [CFG_FMT_W-1:0] FMT_RGB8  = 3'd3;
  localparam logic [CFG_FMT_W-1:0] FMT_RGBA8 = 3'd4;
  localparam logic [CFG_FMT_W-1:0] FMT_D24S8 = 3'd5;

  localparam logic [CFG_DIM_W-1:0] DIM_RESET = 13'd4096;

  typedef struct packed {
    logic [CFG_FMT_W-1:0] pixel_format;
    logic [CFG_DIM_W-1:0] image_width;
    logic [CFG_DIM_W-1:0] image_height;
  } cfg_t;

  // four source pixels of one output and its end-of-image flag
  typedef struct packed {
    logic [PIX_W-1:0] a;
    logic [PIX_W-1:0] b;
    logic [PIX_W-1:0] c;
    logic [PIX_W-1:0] d;
    logic             last;
  } job_t;

  function automatic logic [PIX_W-1:0] avg4(input logic [CFG_FMT_W-1:0] fmt,
                                            input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b,
                                            input logic [PIX_W-1:0] c,
                                            input logic [PIX_W-1:0] d);
    logic [9:0]       s8 [4];
    logic [17:0]      s16;
    logic [25:0]      s24;
    logic [7:0]       q8 [4];
    logic [PIX_W-1:0] res;
    for (int i = 0; i < 4; i++) begin
      s8[i] = 10'(a[i*8 +: 8]) + 10'(b[i*8 +: 8]) + 10'(c[i*8 +: 8]) + 10'(d[i*8 +: 8]);
      q8[i] = s8[i][9:2];
    end
    s16 = 18'(a[15:0]) + 18'(b[15:0]) + 18'(c[15:0]) + 18'(d[15:0]);
    s24 = 26'(a[23:0]) + 26'(b[23:0]) + 26'(c[23:0]) + 26'(d[23:0]);
    case (fmt)
      FMT_R8:    res = {24'd0, q8[0]};
      FMT_RG8:   res = {16'd0, q8[1], q8[0]};
      FMT_R16:   res = {16'd0, s16[17:2]};
      FMT_RGB8:  res = {8'd0, q8[2], q8[1], q8[0]};
      FMT_D24S8: res = {q8[3], s24[25:2]};
      default:   res = {q8[3], q8[2], q8[1], q8[0]};
    endcase
    return res;
  endfunction

endpackage

// ===== hw/rtl/bfd_front.sv =====
// ----------------------------------------------------------------------------
// bfd_front: pixel intake, position counters and line buffer
// Tracks the raster position, sorts each pixel into hold, store or emit,
// keeps even rows in two column banks and registers one job per output.
// ----------------------------------------------------------------------------
module bfd_front (
  input  logic                     clk,
  input  logic                     rst,
  input  bfd_pkg::cfg_t            cfg,
  input  logic                     push,
  output logic                     full,
  input  logic [bfd_pkg::PIX_W-1:0] src_pixel,
  output logic                     job_valid,
  input  logic                     job_ready,
  output bfd_pkg::job_t            job
);

  localparam int DW = bfd_pkg::DIM_W;
  localparam int PW = bfd_pkg::PIX_W;

  logic [bfd_pkg::COL_W-1:0] col;
  logic [bfd_pkg::ROW_W-1:0] row;
  logic [PW-1:0]             held_pixel;

  logic          stage_valid;
  logic [PW-1:0] stage_c;
  logic [PW-1:0] stage_d;
  logic          stage_last;
  logic          stage_mem;

  logic [PW-1:0] bank_even [bfd_pkg::BANK_DEPTH];
  logic [PW-1:0] bank_odd  [bfd_pkg::BANK_DEPTH];
  logic [PW-1:0] rd_even;
  logic [PW-1:0] rd_odd;

  logic [DW-1:0] w_in, h_in, w_eff, h_eff, we, he;
  logic [DW-1:0] col_ext, row_ext, col_p1, row_p1;
  logic          accept, advance;
  logic          emit, last, hold, store, use_mem;
  logic [bfd_pkg::BANK_ADDR_W-1:0] addr;

  assign advance   = stage_valid && job_ready;
  assign full      = stage_valid && !job_ready;
  assign accept    = push && !full;
  assign job_valid = stage_valid;

  always_comb begin
    w_in = DW'(cfg.image_width);
    h_in = DW'(cfg.image_height);
    w_eff = (w_in == '0) ? DW'(1) : w_in;
    if (w_eff > DW'(bfd_pkg::MAX_WIDTH)) w_eff = DW'(bfd_pkg::MAX_WIDTH);
    h_eff = (h_in == '0) ? DW'(1) : h_in;
    if (h_eff > DW'(bfd_pkg::ROW_LIMIT)) h_eff = DW'(bfd_pkg::ROW_LIMIT);
    we = {w_eff[DW-1:1], 1'b0};
    he = {h_eff[DW-1:1], 1'b0};
  end

  assign col_ext = DW'(col);
  assign row_ext = DW'(row);
  assign col_p1  = col_ext + DW'(1);
  assign row_p1  = row_ext + DW'(1);
  assign addr    = bfd_pkg::BANK_ADDR_W'(col >> 1);

  // sort the pixel: hold it, store it in the line buffer, or finish an output
  always_comb begin
    emit    = 1'b0;
    last    = 1'b0;
    hold    = 1'b0;
    store   = 1'b0;
    use_mem = 1'b0;
    if (h_eff == DW'(1)) begin
      if (col_ext < we) begin
        if (!col[0]) begin
          hold = 1'b1;
        end else begin
          emit = 1'b1;
          last = (col_ext == we - DW'(1));
        end
      end
    end else if (w_eff == DW'(1)) begin
      if (row_ext < he && col_ext == '0) begin
        if (!row[0]) begin
          hold = 1'b1;
        end else begin
          emit = 1'b1;
          last = (row_ext == he - DW'(1));
        end
      end
    end else if (row_ext < he && col_ext < we) begin
      if (!row[0]) begin
        store = 1'b1;
      end else if (!col[0]) begin
        hold = 1'b1;
      end else begin
        emit    = 1'b1;
        use_mem = 1'b1;
        last    = (row_ext == he - DW'(1)) && (col_ext == we - DW'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col         <= '0;
      row         <= '0;
      held_pixel  <= '0;
      stage_valid <= 1'b0;
    end else begin
      if (accept) begin
        if (col_p1 >= w_eff) begin
          col <= '0;
          row <= (row_p1 >= h_eff) ? '0 : bfd_pkg::ROW_W'(row_p1);
        end else begin
          col <= bfd_pkg::COL_W'(col_p1);
        end
        if (hold) held_pixel <= src_pixel;
        stage_valid <= emit;
      end else if (advance) begin
        stage_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      stage_c    <= held_pixel;
      stage_d    <= src_pixel;
      stage_last <= last;
      stage_mem  <= use_mem;
    end
  end

  // even columns go to one bank, odd columns to the other
  always_ff @(posedge clk) begin
    if (accept && store && !col[0]) bank_even[addr] <= src_pixel;
    if (accept && use_mem) rd_even <= bank_even[addr];
  end

  always_ff @(posedge clk) begin
    if (accept && store && col[0]) bank_odd[addr] <= src_pixel;
    if (accept && use_mem) rd_odd <= bank_odd[addr];
  end

  always_comb begin
    job.a    = stage_mem ? rd_even : stage_c;
    job.b    = stage_mem ? rd_odd  : stage_d;
    job.c    = stage_c;
    job.d    = stage_d;
    job.last = stage_last;
  end

endmodule

// ===== hw/rtl/bfd_queue.sv =====
// ----------------------------------------------------------------------------
// bfd_queue: short job queue between front and back end
// Two-entry circular buffer; lets either side stall without the other.
// ----------------------------------------------------------------------------
module bfd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  bfd_pkg::job_t wr_job,
  output logic          rd_valid,
  input  logic          rd_take,
  output bfd_pkg::job_t rd_job
);

  localparam int CW = bfd_pkg::QPTR_W + 1;

  bfd_pkg::job_t               slots [bfd_pkg::QUEUE_DEPTH];
  logic [bfd_pkg::QPTR_W-1:0]  wr_ptr;
  logic [bfd_pkg::QPTR_W-1:0]  rd_ptr;
  logic [CW-1:0]               count;
  logic                        do_wr, do_rd;

  assign wr_ready = (count != CW'(bfd_pkg::QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_take && rd_valid;
  assign rd_job   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == bfd_pkg::QPTR_W'(bfd_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == bfd_pkg::QPTR_W'(bfd_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) slots[wr_ptr] <= wr_job;
  end

endmodule

// ===== hw/rtl/bfd_back.sv =====
// ----------------------------------------------------------------------------
// bfd_back: lane averaging and result register
// Pulls one job, averages its four pixels per the format and holds the
// result until the consumer pops it.
// ----------------------------------------------------------------------------
module bfd_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [bfd_pkg::CFG_FMT_W-1:0] pixel_format,
  input  logic                       job_valid,
  output logic                       job_take,
  input  bfd_pkg::job_t              job,
  output logic                       empty,
  input  logic                       pop,
  output logic [bfd_pkg::PIX_W-1:0]  dst_pixel,
  output logic                       last_out
);

  logic out_valid;

  assign empty    = !out_valid;
  // refill when the register is free or its beat leaves this cycle
  assign job_take = job_valid && (!out_valid || pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (job_take) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (job_take) begin
      dst_pixel <= bfd_pkg::avg4(pixel_format, job.a, job.b, job.c, job.d);
      last_out  <= job.last;
    end
  end

endmodule

// ===== hw/rtl/box_filter_2x_downsample_top.sv =====
// ----------------------------------------------------------------------------
// box_filter_2x_downsample_top: 2x2 box filter mip level generator
// Raster pixels in, half-size averaged pixels out, configuration registers
// for format and source size.
// ----------------------------------------------------------------------------
//
//   channel   handshake              payload
//   --------  ---------------------  ---------------------------------
//   input     push / full            src_pixel[31:0]
//   result    empty / pop            dst_pixel[31:0], last_out
//   config    cfg_write              cfg_index[1:0], cfg_data[12:0]
//
// One pixel per clock is accepted while full is low. A result reaches the
// result ports through three register stages: intake stage with line-buffer
// read, job queue, averaging into the result register. Reset clears
// counters, the held pixel and all valid state; the line buffer has no
// reset. A stalled result backs up into the two-entry queue, then the
// intake stage raises full.
// ----------------------------------------------------------------------------
module box_filter_2x_downsample_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [bfd_pkg::PIX_W-1:0]     src_pixel,
  output logic                          empty,
  input  logic                          pop,
  output logic [bfd_pkg::PIX_W-1:0]     dst_pixel,
  output logic                          last_out,
  input  logic                          cfg_write,
  input  logic [bfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bfd_pkg::CFG_DIM_W-1:0] cfg_data
);

  bfd_pkg::cfg_t cfg;
  bfd_pkg::job_t front_job;
  bfd_pkg::job_t queue_job;
  logic          front_valid, queue_ready;
  logic          queue_valid, back_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pixel_format <= bfd_pkg::FMT_RGBA8;
      cfg.image_width  <= bfd_pkg::DIM_RESET;
      cfg.image_height <= bfd_pkg::DIM_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        bfd_pkg::REG_PIXEL_FORMAT: cfg.pixel_format <= cfg_data[bfd_pkg::CFG_FMT_W-1:0];
        bfd_pkg::REG_IMAGE_WIDTH:  cfg.image_width  <= cfg_data;
        bfd_pkg::REG_IMAGE_HEIGHT: cfg.image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  bfd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .push      (push),
    .full      (full),
    .src_pixel (src_pixel),
    .job_valid (front_valid),
    .job_ready (queue_ready),
    .job       (front_job)
  );

  bfd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (front_valid),
    .wr_ready (queue_ready),
    .wr_job   (front_job),
    .rd_valid (queue_valid),
    .rd_take  (back_take),
    .rd_job   (queue_job)
  );

  bfd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .pixel_format (cfg.pixel_format),
    .job_valid    (queue_valid),
    .job_take     (back_take),
    .job          (queue_job),
    .empty        (empty),
    .pop          (pop),
    .dst_pixel    (dst_pixel),
    .last_out     (last_out)
  );

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: 2x2 box filter mip level generator
// Streams raster images of random size and format into the downsampler and
// scores every output beat against an in-bench predictor of the filter. The
// pacing of both queue sides changes from phase to phase. Also covered:
// register changes mid-image, zero and oversize dimensions and unused
// format codes.
// ----------------------------------------------------------------------------
module testbench;
  import bfd_pkg::*;

  localparam int  HALF_PERIOD  = 10;
  localparam int  RESET_CYCLES = 4;
  localparam int  SETTLE       = 8;
  localparam int  QUIET_LIMIT  = 4000;
  localparam int  RAND_PIXELS  = 540;
  localparam int  SHOW_ERRORS  = 10;

  // codes the package leaves unnamed; the block treats them as RGBA8
  localparam logic [CFG_FMT_W-1:0] FMT_SPARE6 = 3'd6;
  localparam logic [CFG_FMT_W-1:0] FMT_SPARE7 = 3'd7;

  typedef enum int {PACE_FULL, PACE_SRC_IDLE, PACE_SINK_STALL, PACE_BOTH} pace_t;
  typedef enum int {FILL_RAND, FILL_ONES, FILL_ZEROS, FILL_ALT} fill_t;

  typedef struct {
    logic [PIX_W-1:0] pix;
    logic             last;
  } mip_beat_t;

  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 push      = 1'b0;
  logic                 full;
  logic [PIX_W-1:0]     src_pixel = '0;
  logic                 empty;
  logic                 pop       = 1'b0;
  logic [PIX_W-1:0]     dst_pixel;
  logic                 last_out;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DIM_W-1:0] cfg_data  = '0;

  box_filter_2x_downsample_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .src_pixel (src_pixel),
    .empty     (empty),
    .pop       (pop),
    .dst_pixel (dst_pixel),
    .last_out  (last_out),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  logic [PIX_W-1:0] pending_pixels[$];
  mip_beat_t        mip_expected[$];
  pace_t            pace = PACE_FULL;

  // predictor state
  logic [CFG_FMT_W-1:0] fmt_reg    = FMT_RGBA8;
  logic [CFG_DIM_W-1:0] width_reg  = DIM_RESET;
  logic [CFG_DIM_W-1:0] height_reg = DIM_RESET;
  logic [PIX_W-1:0]     even_row [MAX_WIDTH];
  logic [PIX_W-1:0]     left_pixel = '0;
  int unsigned          col_pos    = 0;
  int unsigned          row_pos    = 0;

  int errors        = 0;
  int pixels_in     = 0;
  int beats_checked = 0;
  int setups        = 0;
  int quiet         = 0;

  initial begin
    clk = 1'b0;
    forever #HALF_PERIOD clk = ~clk;
  end

  function automatic logic [PIX_W-1:0] lane_mean(input logic [PIX_W-1:0] a, b, c, d,
                                                 input int lsb, input int nbits);
    logic [33:0] msk;
    logic [33:0] total;
    msk   = (34'd1 << nbits) - 34'd1;
    total = ((a >> lsb) & msk) + ((b >> lsb) & msk) + ((c >> lsb) & msk)
          + ((d >> lsb) & msk);
    return PIX_W'(((total >> 2) & msk) << lsb);
  endfunction

  function automatic logic [PIX_W-1:0] box_mean(input logic [PIX_W-1:0] a, b, c, d);
    case (fmt_reg)
      FMT_R8:    return lane_mean(a, b, c, d, 0, 8);
      FMT_RG8:   return lane_mean(a, b, c, d, 0, 8) | lane_mean(a, b, c, d, 8, 8);
      FMT_R16:   return lane_mean(a, b, c, d, 0, 16);
      FMT_RGB8:  return lane_mean(a, b, c, d, 0, 8) | lane_mean(a, b, c, d, 8, 8)
                      | lane_mean(a, b, c, d, 16, 8);
      FMT_D24S8: return lane_mean(a, b, c, d, 0, 24) | lane_mean(a, b, c, d, 24, 8);
      default:   return lane_mean(a, b, c, d, 0, 8) | lane_mean(a, b, c, d, 8, 8)
                      | lane_mean(a, b, c, d, 16, 8) | lane_mean(a, b, c, d, 24, 8);
    endcase
  endfunction

  function automatic int unsigned clamp_dim(input logic [CFG_DIM_W-1:0] v, input int top);
    if (v == 0) return 1;
    if (v > top) return top;
    return 32'(v);
  endfunction

  // advance the filter by one source pixel, queue the mip pixel it completes
  function automatic void mip_predict(input logic [PIX_W-1:0] px);
    int unsigned w, h, we, he;
    logic [PIX_W-1:0] mean;
    logic hit, fin;
    w    = clamp_dim(width_reg, MAX_WIDTH);
    h    = clamp_dim(height_reg, ROW_LIMIT);
    we   = w & ~32'd1;
    he   = h & ~32'd1;
    hit  = 1'b0;
    fin  = 1'b0;
    mean = '0;
    if (h == 1) begin
      if (col_pos < we) begin
        if (col_pos[0] == 1'b0) begin
          left_pixel = px;
        end else begin
          mean = box_mean(left_pixel, px, left_pixel, px);
          hit  = 1'b1;
          fin  = (col_pos == we - 1);
        end
      end
    end else if (w == 1) begin
      if (row_pos < he && col_pos == 0) begin
        if (row_pos[0] == 1'b0) begin
          left_pixel = px;
        end else begin
          mean = box_mean(left_pixel, px, left_pixel, px);
          hit  = 1'b1;
          fin  = (row_pos == he - 1);
        end
      end
    end else if (row_pos < he && col_pos < we && col_pos < MAX_WIDTH) begin
      if (row_pos[0] == 1'b0) begin
        even_row[col_pos] = px;
      end else if (col_pos[0] == 1'b0) begin
        left_pixel = px;
      end else begin
        mean = box_mean(even_row[col_pos - 1], even_row[col_pos], left_pixel, px);
        hit  = 1'b1;
        fin  = (row_pos == he - 1) && (col_pos == we - 1);
      end
    end
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
    if (hit) mip_expected.push_back('{pix: mean, last: fin});
  endfunction

  function automatic logic idle_now(input pace_t side_mode);
    if (pace == PACE_BOTH) return $urandom_range(99) < 19;
    if (pace == side_mode) return $urandom_range(99) < 86;
    return 1'b0;
  endfunction

  // driver: one source pixel per beat
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        mip_predict(src_pixel);
        void'(pending_pixels.pop_front());
        pixels_in++;
      end
      if (push && full) begin
        // hold the offered pixel until it is taken
      end else if (pending_pixels.size() > 0 && !idle_now(PACE_SRC_IDLE)) begin
        push      <= 1'b1;
        src_pixel <= pending_pixels[0];
      end else begin
        push <= 1'b0;
      end
    end
  end

  // monitor: score each mip pixel beat against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (mip_expected.size() == 0) begin
          errors++;
          if (errors <= SHOW_ERRORS)
            $display("tb: unexpected mip pixel %08h last %0b", dst_pixel, last_out);
        end else begin
          mip_beat_t want;
          want = mip_expected.pop_front();
          beats_checked++;
          if (dst_pixel !== want.pix || last_out !== want.last) begin
            errors++;
            if (errors <= SHOW_ERRORS)
              $display("tb: beat %0d: dst_pixel exp %08h got %08h, last_out exp %0b got %0b",
                       beats_checked, want.pix, dst_pixel, want.last, last_out);
          end
        end
      end
      pop <= !idle_now(PACE_SINK_STALL);
    end
  end

  // watchdog on cycles with no beat on any port
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || cfg_write) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("tb: no progress for %0d cycles, %0d predictions outstanding",
                 quiet, mip_expected.size());
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic wait_idle();
    while (pending_pixels.size() != 0 || push || mip_expected.size() != 0)
      @(posedge clk);
    // a pixel may still be in flight that completes nothing
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DIM_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_PIXEL_FORMAT: fmt_reg    = val[CFG_FMT_W-1:0];
      REG_IMAGE_WIDTH:  width_reg  = val;
      REG_IMAGE_HEIGHT: height_reg = val;
      default: ;
    endcase
  endtask

  task automatic setup(input logic [CFG_FMT_W-1:0] f, input int w, input int h);
    wait_idle();
    // spare bits above the format code carry random values
    set_reg(REG_PIXEL_FORMAT, {(CFG_DIM_W-CFG_FMT_W)'($urandom), f});
    set_reg(REG_IMAGE_WIDTH, CFG_DIM_W'(w));
    set_reg(REG_IMAGE_HEIGHT, CFG_DIM_W'(h));
    @(posedge clk);
    cfg_write <= 1'b0;
    setups++;
  endtask

  task automatic send(input int n, input fill_t fill);
    logic [PIX_W-1:0] px;
    for (int i = 0; i < n; i++) begin
      case (fill)
        FILL_ONES:  px = '1;
        FILL_ZEROS: px = '0;
        FILL_ALT:   px = i[0] ? '0 : '1;
        default:    px = $urandom;
      endcase
      pending_pixels.push_back(px);
    end
  endtask

  initial begin
    logic [CFG_FMT_W-1:0] f;
    int    w, h, n, rand_pixels, phase;
    fill_t fill;
    rand_pixels = 0;
    phase       = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed: lane extremes, both degenerate shapes, odd edges, zero size
    setup(FMT_R8, 2, 2);     send(4, FILL_ALT);
    setup(FMT_D24S8, 2, 2);  send(4, FILL_ONES);
    setup(FMT_R16, 4, 1);    send(4, FILL_ONES);
    setup(FMT_RG8, 1, 3);    send(3, FILL_RAND);
    setup(FMT_RGB8, 0, 0);   send(1, FILL_ONES);
    setup(FMT_RGBA8, 3, 3);  send(9, FILL_RAND);

    // shrink the width mid-image: the column beyond the new size wraps silently
    pace = PACE_BOTH;
    setup(FMT_RGBA8, 8, 6);  send(11, FILL_RAND);
    setup(FMT_D24S8, 2, 6);  send(9, FILL_RAND);
    // oversize height, then cut it mid-image so the row counter wraps
    setup(FMT_R16, 1, 5000); send(10, FILL_RAND);
    setup(FMT_R16, 1, 4);    send(5, FILL_RAND);

    // random images, mostly small, pacing rotating per phase
    while (rand_pixels < RAND_PIXELS) begin
      pace = pace_t'(phase % 4);
      f    = CFG_FMT_W'($urandom_range(7));
      w    = $urandom_range(12);
      h    = $urandom_range(8);
      setup(f, w, h);
      n = clamp_dim(CFG_DIM_W'(w), MAX_WIDTH) * clamp_dim(CFG_DIM_W'(h), ROW_LIMIT);
      repeat ($urandom_range(1, 3)) begin
        case ($urandom_range(9))
          0:       fill = FILL_ONES;
          1:       fill = FILL_ZEROS;
          default: fill = FILL_RAND;
        endcase
        send(n, fill);
        rand_pixels += n;
      end
      phase++;
    end

    // oversize and full widths on a single row: the width clamp
    pace = PACE_FULL;
    setup(FMT_SPARE6, 8191, 1);        send(24, FILL_RAND);
    setup(FMT_SPARE7, MAX_WIDTH, 1);   send(24, FILL_RAND);

    wait_idle();
    $display("summary: %0d source pixels, %0d mip pixels checked, %0d register setups",
             pixels_in, beats_checked, setups);
    $display("summary: all pixel formats, degenerate and clamped sizes, four pacing modes");
    if (errors == 0 && mip_expected.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: %0d errors", errors);
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== box_filter_2x_downsample_top.f =====
hw/rtl/bfd_pkg.sv
hw/rtl/bfd_front.sv
hw/rtl/bfd_queue.sv
hw/rtl/bfd_back.sv
hw/rtl/box_filter_2x_downsample_top.sv
verif/testbench.sv
